FILE: rtl/core/quaternion_vector_rotation_macros.svh
// assertion macros for the quaternion rotation core
// no dependencies; included by the top level only
`ifndef QUATERNION_VECTOR_ROTATION_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_MACROS_SVH

`ifndef SYNTHESIS
`define QVR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define QVR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/qvr_pkg.sv
// types and constants shared by the quaternion rotation core
// no dependencies
`default_nettype none

package qvr_pkg;

   typedef logic signed [15:0] comp_type;
   typedef logic signed [31:0] mid_type;
   typedef logic signed [47:0] wide_type;
   typedef logic signed [19:0] rnd_type;

   localparam comp_type Q_ONE      = 16'sd16384;
   localparam comp_type Q_MINUS    = -16'sd16384;
   localparam int       OUT_SHIFT  = 28;
   localparam wide_type ROUND_BIAS = wide_type'(48'sd1 <<< (OUT_SHIFT - 1));
   localparam rnd_type  RESULT_MAX = 20'sd32767;
   localparam rnd_type  RESULT_MIN = -20'sd32768;

   typedef struct packed {
      comp_type vec_x;
      comp_type vec_y;
      comp_type vec_z;
      comp_type quat_w;
      comp_type quat_x;
      comp_type quat_y;
      comp_type quat_z;
   } req_type;

   typedef struct packed {
      comp_type rot_x;
      comp_type rot_y;
      comp_type rot_z;
      logic     clipped;
   } rsp_type;

   // quaternion plus the product v * conj(q)
   typedef struct packed {
      comp_type q_w;
      comp_type q_x;
      comp_type q_y;
      comp_type q_z;
      mid_type  t_w;
      mid_type  t_x;
      mid_type  t_y;
      mid_type  t_z;
   } half_type;

   // exact vector part of q * t, Q.39
   typedef struct packed {
      wide_type p_x;
      wide_type p_y;
      wide_type p_z;
   } full_type;

   function automatic comp_type clamp_q(comp_type v);
      comp_type r;
      r = v;
      if (v > Q_ONE) r = Q_ONE;
      if (v < Q_MINUS) r = Q_MINUS;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qvr_conj_mult.sv
// first hamilton product (0,v) * conj(q): product stage then sum stage
// depends on qvr_pkg
`default_nettype none

module qvr_conj_mult (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  qvr_pkg::req_type      in_data,
   output logic                  in_stall,
   output logic                  out_valid,
   output qvr_pkg::half_type     out_data,
   input  wire logic             out_stall
);
   import qvr_pkg::*;

   logic     prod_valid_ff;
   mid_type  prod_in [12];
   mid_type  prod_ff [12];
   comp_type qw_ff, qx_ff, qy_ff, qz_ff;
   logic     sum_valid_ff;
   half_type sum_in;
   half_type sum_ff;
   logic     prod_ready, sum_ready;

   assign sum_ready  = !sum_valid_ff || !out_stall;
   assign prod_ready = !prod_valid_ff || sum_ready;
   assign in_stall   = !prod_ready;
   assign out_valid  = sum_valid_ff;
   assign out_data   = sum_ff;

   always_comb begin
      prod_in[0]  = mid_type'(in_data.vec_x) * mid_type'(in_data.quat_x);
      prod_in[1]  = mid_type'(in_data.vec_y) * mid_type'(in_data.quat_y);
      prod_in[2]  = mid_type'(in_data.vec_z) * mid_type'(in_data.quat_z);
      prod_in[3]  = mid_type'(in_data.vec_x) * mid_type'(in_data.quat_w);
      prod_in[4]  = mid_type'(in_data.vec_y) * mid_type'(in_data.quat_z);
      prod_in[5]  = mid_type'(in_data.vec_z) * mid_type'(in_data.quat_y);
      prod_in[6]  = mid_type'(in_data.vec_x) * mid_type'(in_data.quat_z);
      prod_in[7]  = mid_type'(in_data.vec_y) * mid_type'(in_data.quat_w);
      prod_in[8]  = mid_type'(in_data.vec_z) * mid_type'(in_data.quat_x);
      prod_in[9]  = mid_type'(in_data.vec_x) * mid_type'(in_data.quat_y);
      prod_in[10] = mid_type'(in_data.vec_y) * mid_type'(in_data.quat_x);
      prod_in[11] = mid_type'(in_data.vec_z) * mid_type'(in_data.quat_w);
   end

   // the conjugate flips the sign of the i, j, k terms
   always_comb begin
      sum_in.q_w = qw_ff;
      sum_in.q_x = qx_ff;
      sum_in.q_y = qy_ff;
      sum_in.q_z = qz_ff;
      sum_in.t_w = prod_ff[0] + prod_ff[1] + prod_ff[2];
      sum_in.t_x = prod_ff[3] - prod_ff[4] + prod_ff[5];
      sum_in.t_y = prod_ff[6] + prod_ff[7] - prod_ff[8];
      sum_in.t_z = prod_ff[11] + prod_ff[10] - prod_ff[9];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) prod_valid_ff <= in_valid;
         if (sum_ready) sum_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && in_valid) begin
         prod_ff <= prod_in;
         qw_ff   <= in_data.quat_w;
         qx_ff   <= in_data.quat_x;
         qy_ff   <= in_data.quat_y;
         qz_ff   <= in_data.quat_z;
      end
      if (sum_ready && prod_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/qvr_ham_mult.sv
// second hamilton product q * t, vector part only: product stage then sum stage
// depends on qvr_pkg
`default_nettype none

module qvr_ham_mult (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  qvr_pkg::half_type     in_data,
   output logic                  in_stall,
   output logic                  out_valid,
   output qvr_pkg::full_type     out_data,
   input  wire logic             out_stall
);
   import qvr_pkg::*;

   logic     prod_valid_ff;
   wide_type prod_in [12];
   wide_type prod_ff [12];
   logic     sum_valid_ff;
   full_type sum_in;
   full_type sum_ff;
   logic     prod_ready, sum_ready;

   assign sum_ready  = !sum_valid_ff || !out_stall;
   assign prod_ready = !prod_valid_ff || sum_ready;
   assign in_stall   = !prod_ready;
   assign out_valid  = sum_valid_ff;
   assign out_data   = sum_ff;

   always_comb begin
      prod_in[0]  = wide_type'(in_data.q_w) * wide_type'(in_data.t_x);
      prod_in[1]  = wide_type'(in_data.q_x) * wide_type'(in_data.t_w);
      prod_in[2]  = wide_type'(in_data.q_y) * wide_type'(in_data.t_z);
      prod_in[3]  = wide_type'(in_data.q_z) * wide_type'(in_data.t_y);
      prod_in[4]  = wide_type'(in_data.q_w) * wide_type'(in_data.t_y);
      prod_in[5]  = wide_type'(in_data.q_x) * wide_type'(in_data.t_z);
      prod_in[6]  = wide_type'(in_data.q_y) * wide_type'(in_data.t_w);
      prod_in[7]  = wide_type'(in_data.q_z) * wide_type'(in_data.t_x);
      prod_in[8]  = wide_type'(in_data.q_w) * wide_type'(in_data.t_z);
      prod_in[9]  = wide_type'(in_data.q_x) * wide_type'(in_data.t_y);
      prod_in[10] = wide_type'(in_data.q_y) * wide_type'(in_data.t_x);
      prod_in[11] = wide_type'(in_data.q_z) * wide_type'(in_data.t_w);
   end

   always_comb begin
      sum_in.p_x = prod_ff[0] + prod_ff[1] + prod_ff[2] - prod_ff[3];
      sum_in.p_y = prod_ff[4] - prod_ff[5] + prod_ff[6] + prod_ff[7];
      sum_in.p_z = prod_ff[8] + prod_ff[9] - prod_ff[10] + prod_ff[11];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) prod_valid_ff <= in_valid;
         if (sum_ready) sum_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && in_valid) begin
         prod_ff <= prod_in;
      end
      if (sum_ready && prod_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/qvr_round_sat.sv
// rounding to Q4.11 and saturation, with the output register
// depends on qvr_pkg
`default_nettype none

module qvr_round_sat (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  qvr_pkg::full_type     in_data,
   output logic                  in_stall,
   output logic                  out_valid,
   output qvr_pkg::rsp_type      out_data,
   input  wire logic             out_stall
);
   import qvr_pkg::*;

   logic    rsp_valid_ff;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_ready;
   logic    clip_x, clip_y, clip_z;

   // {saturated flag, value}; round half up is add half lsb then floor
   function automatic logic [16:0] round_sat(wide_type p);
      wide_type biased;
      rnd_type  shifted;
      logic [16:0] r;
      biased  = p + ROUND_BIAS;
      shifted = rnd_type'(biased >>> OUT_SHIFT);
      r = {1'b0, shifted[15:0]};
      if (shifted > RESULT_MAX) r = {1'b1, 16'h7fff};
      if (shifted < RESULT_MIN) r = {1'b1, 16'h8000};
      return r;
   endfunction

   assign rsp_ready = !rsp_valid_ff || !out_stall;
   assign in_stall  = !rsp_ready;
   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

   always_comb begin
      {clip_x, rsp_in.rot_x} = round_sat(in_data.p_x);
      {clip_y, rsp_in.rot_y} = round_sat(in_data.p_y);
      {clip_z, rsp_in.rot_z} = round_sat(in_data.p_z);
      rsp_in.clipped = clip_x | clip_y | clip_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/quaternion_vector_rotation.sv
// a result reaches rsp_valid after its request transfer has passed through six register
// stages: input clamp, two multiply stages, two sum stages, round
// throughput: one item per cycle; each stage holds only while the stage after it is full
// and stalled, so bubbles are squeezed out. reset clears every valid bit, payloads keep
// whatever they held. depends on qvr_pkg, qvr_conj_mult, qvr_ham_mult, qvr_round_sat
`default_nettype none
`include "quaternion_vector_rotation_macros.svh"

module quaternion_vector_rotation (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  qvr_pkg::req_type      req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output qvr_pkg::rsp_type      rsp_data,
   input  wire logic             rsp_stall
);
   import qvr_pkg::*;

   logic     s0_valid_ff;
   req_type  s0_data_in;
   req_type  s0_data_ff;
   logic     s0_ready;
   logic     conj_stall;
   logic     half_valid;
   half_type half_data;
   logic     ham_stall;
   logic     full_valid;
   full_type full_data;
   logic     rnd_stall;

   assign s0_ready  = !s0_valid_ff || !conj_stall;
   assign req_stall = !s0_ready;

   // out-of-range quaternion parts are clamped to plus or minus one
   always_comb begin
      s0_data_in        = req_data;
      s0_data_in.quat_w = clamp_q(req_data.quat_w);
      s0_data_in.quat_x = clamp_q(req_data.quat_x);
      s0_data_in.quat_y = clamp_q(req_data.quat_y);
      s0_data_in.quat_z = clamp_q(req_data.quat_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_valid) begin
         s0_data_ff <= s0_data_in;
      end
   end

   qvr_conj_mult u_conj_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_data   (s0_data_ff),
      .in_stall  (conj_stall),
      .out_valid (half_valid),
      .out_data  (half_data),
      .out_stall (ham_stall)
   );

   qvr_ham_mult u_ham_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (half_valid),
      .in_data   (half_data),
      .in_stall  (ham_stall),
      .out_valid (full_valid),
      .out_data  (full_data),
      .out_stall (rnd_stall)
   );

   qvr_round_sat u_round_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (full_valid),
      .in_data   (full_data),
      .in_stall  (rnd_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   // a free output means every stage can move, so the input must be open
   `QVR_ASSERT_IMPL(open_when_drained, clock, reset, !rsp_stall, !req_stall)
   // a request transfer always lands in the input stage
   `QVR_ASSERT_NEXT(req_lands, clock, reset, req_valid && !req_stall, s0_valid_ff)
   // the flag is only set when some component sits at a rail
   `QVR_ASSERT_IMPL(clip_at_rail, clock, reset, rsp_valid && rsp_data.clipped,
      rsp_data.rot_x == 16'sh7fff || rsp_data.rot_x == -16'sh8000 ||
      rsp_data.rot_y == 16'sh7fff || rsp_data.rot_y == -16'sh8000 ||
      rsp_data.rot_z == 16'sh7fff || rsp_data.rot_z == -16'sh8000)

endmodule

`default_nettype wire

FILE: tb/sv/quaternion_vector_rotation_tb.sv
// self-checking testbench for quaternion_vector_rotation: q * (0,v) * conj(q) per transfer
// typed rows give results; untyped rows, random items: local fixed-point rotation model
// depends on qvr_pkg and the quaternion_vector_rotation rtl
`default_nettype none

module quaternion_vector_rotation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qvr_pkg::*;

   localparam int RANDOM_ITEMS  = 630;
   localparam int QUIET_ITEMS   = 100;
   localparam int HOLD_CYCLES   = 48;
   localparam int HOLD_AFTER    = 60;
   localparam int SETTLE_CYCLES = 12;
   localparam int ROUND_SHIFT   = 28;
   localparam longint SAT_HIGH  = 32767;
   localparam longint SAT_LOW   = -32768;

   // columns: vec x y z, quat w x y z, typed, rot x y z, clipped
   localparam int DIRECTED_ROWS = 22;
   localparam int DIRECTED_TABLE [DIRECTED_ROWS][12] = '{
      '{  2048,  -2048,   4096,  16384,      0,     0,      0, 1,   2048,  -2048,  4096, 0},
      '{ 32767, -32768,      0,  16384,      0,     0,      0, 1,  32767, -32768,     0, 0},
      '{ 32767,  32767, -32768,      0,      0,     0,      0, 1,      0,      0,     0, 0},
      '{     0,      0,      0,  16384,  16384, 16384,  16384, 1,      0,      0,     0, 0},
      '{   100,   -200,    300,  32767,      0,     0,      0, 1,    100,   -200,   300, 0},
      '{    -5,      6,     -7, -32768,      0,     0,      0, 1,     -5,      6,    -7, 0},
      '{-32768, -32768, -32768, -16384,      0,     0,      0, 1, -32768, -32768, -32768, 0},
      '{  1000,   2000,   3000,      0,      0,     0,  16384, 1,  -1000,  -2000,  3000, 0},
      '{-32768,  32767,      5,      0,      0,     0,  16384, 1,  32767, -32767,     5, 1},
      '{     7, -32768, -32768,      0,  16384,     0,      0, 1,      7,  32767, 32767, 1},
      '{ 32767,    123, -32767,      0,      0, 16384,      0, 1, -32767,    123, 32767, 0},
      '{ 20000, -20000,  10000,  16384,  16384, 16384,  16384, 0,      0,      0,     0, 0},
      '{ 32767,  32767,  32767, -16384, -16384, -16384, -16384, 0,     0,      0,     0, 0},
      '{  1234,  -4321,    777,  32767, -32768, 32767, -32768, 0,      0,      0,     0, 0},
      '{  2048,   2048,   2048,  11585,  11585,     0,      0, 0,      0,      0,     0, 0},
      '{     2,     -2,      1,   8192,      0,     0,      0, 0,      0,      0,     0, 0},
      '{    -1,      3,     -3,   8192,      0,     0,      0, 0,      0,      0,     0, 0},
      '{-32768, -32768, -32768,  16384,  16384,     0,      0, 0,      0,      0,     0, 0},
      '{ 32767,  32767,  32767, -16384,  16384, -16384, 16384, 0,      0,      0,     0, 0},
      '{  -100,    200,   -300,  16385, -16385, 16385, -16385, 0,      0,      0,     0, 0},
      '{ 21845, -21846,  21845,  21845, -21846,  5461,  -5462, 0,      0,      0,     0, 0},
      '{ 32767, -32768,  32767,      1,     -1,     1,     -1, 0,      0,      0,     0, 0}
   };

   typedef struct packed {
      longint w;
      longint x;
      longint y;
      longint z;
   } wide_quat_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   req_type req_data;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall;

   rsp_type pending_rotations[$];
   int      error_count  = 0;
   int      transfers_in = 0;
   bit      quiet_tail   = 1'b0;
   bit      hold_done    = 1'b0;

   quaternion_vector_rotation dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   function automatic longint limit_unit(comp_type c);
      longint v;
      v = longint'(c);
      if (v > longint'(Q_ONE)) v = longint'(Q_ONE);
      if (v < -longint'(Q_ONE)) v = -longint'(Q_ONE);
      return v;
   endfunction

   function automatic wide_quat_type hamilton(wide_quat_type a, wide_quat_type b);
      wide_quat_type r;
      r.w = a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z;
      r.x = a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y;
      r.y = a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x;
      r.z = a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w;
      return r;
   endfunction

   function automatic rsp_type rotate_vector(req_type r);
      wide_quat_type vq;
      wide_quat_type q;
      wide_quat_type qc;
      wide_quat_type p;
      longint        part [3];
      longint        rounded;
      rsp_type       res;
      comp_type      out_c [3];
      vq = '{w: 0, x: longint'(r.vec_x), y: longint'(r.vec_y), z: longint'(r.vec_z)};
      q.w = limit_unit(r.quat_w);
      q.x = limit_unit(r.quat_x);
      q.y = limit_unit(r.quat_y);
      q.z = limit_unit(r.quat_z);
      qc = '{w: q.w, x: -q.x, y: -q.y, z: -q.z};
      p = hamilton(q, hamilton(vq, qc));
      part[0] = p.x;
      part[1] = p.y;
      part[2] = p.z;
      res.clipped = 1'b0;
      for (int i = 0; i < 3; i++) begin
         // half rounds up: add half an lsb then floor
         rounded = (part[i] + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
         if (rounded > SAT_HIGH) begin
            rounded = SAT_HIGH;
            res.clipped = 1'b1;
         end else if (rounded < SAT_LOW) begin
            rounded = SAT_LOW;
            res.clipped = 1'b1;
         end
         out_c[i] = comp_type'(rounded);
      end
      res.rot_x = out_c[0];
      res.rot_y = out_c[1];
      res.rot_z = out_c[2];
      return res;
   endfunction

   function automatic comp_type random_vec_part();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return comp_type'(SAT_HIGH);
               1: return comp_type'(SAT_LOW);
               2: return '0;
               3: return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         1: return comp_type'(int'($urandom_range(0, 128)) - 64);
         default: return comp_type'($urandom);
      endcase
   endfunction

   function automatic comp_type random_quat_part();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 6))
               0: return '0;
               1: return Q_ONE;
               2: return Q_MINUS;
               3: return Q_ONE + 16'sd1;
               4: return Q_MINUS - 16'sd1;
               5: return comp_type'(SAT_HIGH);
               default: return comp_type'(SAT_LOW);
            endcase
         end
         1: return comp_type'($urandom);
         default: return comp_type'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_request(input req_type item, input rsp_type want);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rotations.push_back(want);
      transfers_in++;
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #200000;
      $display("FAILURE");
      $finish;
   end

   // receiver: short random stalls, plus one long hold to back the pipeline up
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && transfers_in >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rotations.size() == 0) begin
            $display("%0t: result transfer with nothing expected, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_rotations.pop_front();
            if (rsp_data.rot_x !== want.rot_x) begin
               $display("%0t: rot_x expected %0d actual %0d", $time, want.rot_x, rsp_data.rot_x);
               error_count++;
            end
            if (rsp_data.rot_y !== want.rot_y) begin
               $display("%0t: rot_y expected %0d actual %0d", $time, want.rot_y, rsp_data.rot_y);
               error_count++;
            end
            if (rsp_data.rot_z !== want.rot_z) begin
               $display("%0t: rot_z expected %0d actual %0d", $time, want.rot_z, rsp_data.rot_z);
               error_count++;
            end
            if (rsp_data.clipped !== want.clipped) begin
               $display("%0t: clipped expected %0b actual %0b", $time, want.clipped,
                        rsp_data.clipped);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_type item;
      rsp_type want;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         item.vec_x  = comp_type'(DIRECTED_TABLE[row][0]);
         item.vec_y  = comp_type'(DIRECTED_TABLE[row][1]);
         item.vec_z  = comp_type'(DIRECTED_TABLE[row][2]);
         item.quat_w = comp_type'(DIRECTED_TABLE[row][3]);
         item.quat_x = comp_type'(DIRECTED_TABLE[row][4]);
         item.quat_y = comp_type'(DIRECTED_TABLE[row][5]);
         item.quat_z = comp_type'(DIRECTED_TABLE[row][6]);
         if (DIRECTED_TABLE[row][7] != 0) begin
            want.rot_x   = comp_type'(DIRECTED_TABLE[row][8]);
            want.rot_y   = comp_type'(DIRECTED_TABLE[row][9]);
            want.rot_z   = comp_type'(DIRECTED_TABLE[row][10]);
            want.clipped = DIRECTED_TABLE[row][11][0];
         end else begin
            want = rotate_vector(item);
         end
         send_request(item, want);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);
         item.vec_x  = random_vec_part();
         item.vec_y  = random_vec_part();
         item.vec_z  = random_vec_part();
         item.quat_w = random_quat_part();
         item.quat_x = random_quat_part();
         item.quat_y = random_quat_part();
         item.quat_z = random_quat_part();
         send_request(item, rotate_vector(item));
      end
      req_valid <= 1'b0;

      while (pending_rotations.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
